// File: design/gbba_pkg.sv
// Shared types and constants for the grouped bitmap block allocator.
// Holds field widths, result status codes and the controller/datapath command bundles.
// No dependencies.
`timescale 1ns / 1ps

package gbba_pkg;

    // Default geometry, used as parameter defaults on the top level.
    localparam int NUM_GROUPS_DEF   = 8;
    localparam int GROUP_BLOCKS_DEF = 1024;
    localparam int MAX_REQUEST_DEF  = 64;

    // Fixed field widths of the request, result and configuration channels and of the bitmap word.
    localparam int COUNT_W    = 7;
    localparam int BLOCK_W    = 14;
    localparam int STATUS_W   = 2;
    localparam int WORD_W     = 64;
    localparam int GIU_W      = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    typedef logic [STATUS_W-1:0] t_status;

    // Result status codes.
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_NOSPACE  = 2'd1;
    localparam t_status ST_INVALID  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GROUPS_IN_USE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DATA_BLOCK = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load_in;
        logic    sum_clear;
        logic    sum_step;
        logic    div_step;
        logic    gi_inc;
        logic    gi_clr;
        logic    set_fit;
        logic    best_step;
        logic    set_best;
        logic    rd;
        logic    ld_word;
        logic    claim;
        logic    word_inc;
        logic    free_commit;
        logic    emit;
        t_status emit_st;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cfg_wr;
        logic cfg_giu_wr;
        logic out_free;
        logic is_free;
        logic bad_count;
        logic nospace;
        logic free_bad;
        logic sum_last;
        logic rel_lt;
        logic gi_ge_giu;
        logic gi_last;
        logic fit;
        logic bit_set;
        logic has_free;
        logic left_one;
        logic take_one;
    } t_stat;

endpackage

// File: design/gbba_ram.sv
// Generic single-port RAM with registered read data.
// Used for the block usage bitmap. No dependencies.
`timescale 1ns / 1ps

module gbba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write or one read per cycle; read data appears the next cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/gbba_ctrl.sv
// Controller state machine of the block allocator.
// Sequences checks, group scans, bitmap reads and claims. Depends on gbba_pkg.
`timescale 1ns / 1ps

module gbba_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  gbba_pkg::t_stat i_stat,
    output gbba_pkg::t_cmd  o_cmd
);
    import gbba_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SUM   = 4'd1;
    localparam logic [3:0] S_CHECK = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_WAIT  = 4'd4;
    localparam logic [3:0] S_FCHK  = 4'd5;
    localparam logic [3:0] S_EBAD  = 4'd6;
    localparam logic [3:0] S_ENOSP = 4'd7;
    localparam logic [3:0] S_EFOK  = 4'd8;
    localparam logic [3:0] S_FIND  = 4'd9;
    localparam logic [3:0] S_BEST  = 4'd10;
    localparam logic [3:0] S_SETB  = 4'd11;
    localparam logic [3:0] S_RD    = 4'd12;
    localparam logic [3:0] S_CLAIM = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;
    t_cmd       w_cmd;

    // Requests are taken only when idle and no configuration write is under way.
    assign o_stall = (r_state != S_IDLE) || i_stat.cfg_wr;

    // Next state and command decode.
    always_comb begin
        n_state       = r_state;
        w_cmd         = '0;
        w_cmd.emit_st = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_stat.cfg_giu_wr) begin
                    w_cmd.sum_clear = 1'b1;
                    n_state         = S_SUM;
                end else if (i_valid && !o_stall) begin
                    w_cmd.load_in = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_SUM: begin
                if (i_stat.cfg_giu_wr) begin
                    w_cmd.sum_clear = 1'b1;
                end else begin
                    w_cmd.sum_step = 1'b1;
                    if (i_stat.sum_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_CHECK: begin
                if (i_stat.is_free) begin
                    n_state = i_stat.free_bad ? S_EBAD : S_DIV;
                end else if (i_stat.bad_count) begin
                    n_state = S_EBAD;
                end else if (i_stat.nospace) begin
                    n_state = S_ENOSP;
                end else begin
                    n_state = S_FIND;
                end
            end
            S_DIV: begin
                if (i_stat.gi_ge_giu) begin
                    n_state = S_EBAD;
                end else if (i_stat.rel_lt) begin
                    w_cmd.rd = 1'b1;
                    n_state  = S_WAIT;
                end else begin
                    w_cmd.div_step = 1'b1;
                end
            end
            S_WAIT: begin
                w_cmd.ld_word = 1'b1;
                n_state       = i_stat.is_free ? S_FCHK : S_CLAIM;
            end
            S_FCHK: begin
                n_state = i_stat.bit_set ? S_EFOK : S_EBAD;
            end
            S_EBAD: begin
                if (i_stat.out_free) begin
                    w_cmd.emit    = 1'b1;
                    w_cmd.emit_st = ST_INVALID;
                    n_state       = S_IDLE;
                end
            end
            S_ENOSP: begin
                if (i_stat.out_free) begin
                    w_cmd.emit    = 1'b1;
                    w_cmd.emit_st = ST_NOSPACE;
                    n_state       = S_IDLE;
                end
            end
            S_EFOK: begin
                if (i_stat.out_free) begin
                    w_cmd.emit        = 1'b1;
                    w_cmd.free_commit = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_FIND: begin
                if (i_stat.fit) begin
                    w_cmd.set_fit = 1'b1;
                    n_state       = S_RD;
                end else if (i_stat.gi_last) begin
                    w_cmd.gi_clr = 1'b1;
                    n_state      = S_BEST;
                end else begin
                    w_cmd.gi_inc = 1'b1;
                end
            end
            S_BEST: begin
                w_cmd.best_step = 1'b1;
                if (i_stat.gi_last) begin
                    n_state = S_SETB;
                end
            end
            S_SETB: begin
                w_cmd.set_best = 1'b1;
                n_state        = S_RD;
            end
            S_RD: begin
                w_cmd.rd = 1'b1;
                n_state  = S_WAIT;
            end
            S_CLAIM: begin
                if (!i_stat.has_free) begin
                    w_cmd.word_inc = 1'b1;
                    n_state        = S_RD;
                end else if (i_stat.out_free) begin
                    w_cmd.claim = 1'b1;
                    w_cmd.emit  = 1'b1;
                    if (i_stat.left_one) begin
                        n_state = S_IDLE;
                    end else if (i_stat.take_one) begin
                        w_cmd.gi_clr = 1'b1;
                        n_state      = S_BEST;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd = w_cmd;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: design/gbba_dp.sv
// Datapath of the block allocator: configuration, group counts, bitmap RAM,
// working registers and the result register. Depends on gbba_pkg and gbba_ram.
`timescale 1ns / 1ps

module gbba_dp #(
    parameter int NUM_GROUPS   = gbba_pkg::NUM_GROUPS_DEF,
    parameter int GROUP_BLOCKS = gbba_pkg::GROUP_BLOCKS_DEF,
    parameter int MAX_REQUEST  = gbba_pkg::MAX_REQUEST_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gbba_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [gbba_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_mode,
    input  logic [gbba_pkg::COUNT_W-1:0]        i_count,
    input  logic [gbba_pkg::BLOCK_W-1:0]        i_block_number,
    input  logic                                i_stall,
    input  gbba_pkg::t_cmd                      i_cmd,
    output gbba_pkg::t_stat                     o_stat,
    output logic                                o_valid,
    output logic [gbba_pkg::BLOCK_W-1:0]        o_block_number_res,
    output gbba_pkg::t_status                   o_status,
    output logic                                o_last
);
    import gbba_pkg::*;

    localparam int WPG       = (GROUP_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int DEPTH     = NUM_GROUPS * WPG;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int GW        = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int GIW       = $clog2(NUM_GROUPS + 1);
    localparam int WW        = (WPG > 1) ? $clog2(WPG) : 1;
    localparam int CW        = $clog2(GROUP_BLOCKS + 1);
    localparam int TW        = $clog2(NUM_GROUPS * GROUP_BLOCKS + 1);
    localparam int BW        = $clog2(WORD_W);
    localparam int LAST_BITS = GROUP_BLOCKS - (WPG - 1) * WORD_W;
    localparam int GIU_RST   = (NUM_GROUPS < 8) ? NUM_GROUPS : 8;
    localparam logic [WORD_W-1:0] LAST_MASK = {WORD_W{1'b1}} >> (WORD_W - LAST_BITS);

    // Configuration registers.
    logic [GIW-1:0]     r_giu;
    logic               r_fdb;
    // Group and total free counts.
    logic [CW-1:0]      r_gcnt [NUM_GROUPS];
    logic [TW-1:0]      r_total;
    logic [TW-1:0]      r_sum;
    // Valid bits of the bitmap words; an unwritten word reads as all free.
    logic [DEPTH-1:0]   r_wvalid;
    logic               r_rd_valid;
    // Request and working registers.
    logic               r_mode;
    logic [COUNT_W-1:0] r_count;
    logic [BLOCK_W-1:0] r_block;
    logic [BLOCK_W-1:0] r_rel;
    logic [GIW-1:0]     r_gi;
    logic [GW-1:0]      r_best;
    logic [CW-1:0]      r_bestv;
    logic [GW-1:0]      r_tgt;
    logic [COUNT_W-1:0] r_left;
    logic [COUNT_W-1:0] r_take;
    logic [WW-1:0]      r_word;
    logic [WORD_W-1:0]  r_wreg;
    // Result register.
    logic               r_o_valid;
    logic [BLOCK_W-1:0] r_o_bn;
    t_status            r_o_st;
    logic               r_o_last;

    logic [CW-1:0]      w_gcnt_gi;
    logic [TW-1:0]      w_sum_n;
    logic [GIW-1:0]     w_giu_n;
    logic [WORD_W-1:0]  w_freeb;
    logic [WORD_W-1:0]  w_lowbit;
    logic [BW-1:0]      w_bitidx;
    logic [31:0]        w_claim_bn;
    logic [31:0]        w_addr_full;
    logic [AW-1:0]      w_addr;
    logic               w_we;
    logic [WORD_W-1:0]  w_wdata;
    logic [WORD_W-1:0]  w_claimed;
    logic [WORD_W-1:0]  w_rdata;
    logic               w_out_free;
    logic [BLOCK_W-1:0] w_emit_bn;
    logic               w_emit_last;

    // Count of the group under the scan index.
    assign w_gcnt_gi = r_gcnt[r_gi[GW-1:0]];
    assign w_sum_n   = r_sum + TW'(w_gcnt_gi);

    // Clamp of a groups-in-use write to 1..NUM_GROUPS.
    always_comb begin
        if (i_cfg_data == '0) begin
            w_giu_n = GIW'(1);
        end else if (32'(i_cfg_data) > NUM_GROUPS) begin
            w_giu_n = GIW'(NUM_GROUPS);
        end else begin
            w_giu_n = GIW'(i_cfg_data);
        end
    end

    // Free bits of the held word and its lowest one.
    assign w_freeb   = ~r_wreg & ((r_word == WW'(WPG - 1)) ? LAST_MASK : {WORD_W{1'b1}});
    assign w_lowbit  = w_freeb & (~w_freeb + WORD_W'(1));
    assign w_claimed = r_wreg | w_lowbit;

    always_comb begin
        w_bitidx = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (w_lowbit[i]) begin
                w_bitidx = w_bitidx | BW'(i);
            end
        end
    end

    assign w_claim_bn = 32'(r_fdb) + 32'(r_tgt) * GROUP_BLOCKS
                      + (32'(r_word) << BW) + 32'(w_bitidx);

    // Bitmap address: the freed block's word, or the scanned word of the target group.
    assign w_addr_full = r_mode ? (32'(r_gi) * WPG + 32'(r_rel >> BW))
                                : (32'(r_tgt) * WPG + 32'(r_word));
    assign w_addr      = w_addr_full[AW-1:0];
    assign w_we        = i_cmd.claim || i_cmd.free_commit;
    assign w_wdata     = i_cmd.claim ? w_claimed
                                     : (r_wreg & ~(WORD_W'(1) << r_rel[BW-1:0]));

    gbba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    // Configuration, counts and valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_giu    <= GIW'(GIU_RST);
            r_fdb    <= 1'b1;
            r_total  <= TW'(GIU_RST * GROUP_BLOCKS);
            r_wvalid <= '0;
            for (int g = 0; g < NUM_GROUPS; g++) begin
                r_gcnt[g] <= CW'(GROUP_BLOCKS);
            end
        end else begin
            if (i_cfg_we && i_cfg_index == CFG_GROUPS_IN_USE) begin
                r_giu <= w_giu_n;
            end
            if (i_cfg_we && i_cfg_index == CFG_FIRST_DATA_BLOCK) begin
                r_fdb <= i_cfg_data[0];
            end
            if (w_we) begin
                r_wvalid[w_addr] <= 1'b1;
            end
            if (i_cmd.sum_step && o_stat.sum_last) begin
                r_total <= w_sum_n;
            end else if (i_cmd.claim) begin
                r_total <= r_total - TW'(1);
            end else if (i_cmd.free_commit) begin
                r_total <= r_total + TW'(1);
            end
            if (i_cmd.claim) begin
                r_gcnt[r_tgt] <= r_gcnt[r_tgt] - CW'(1);
            end else if (i_cmd.free_commit) begin
                r_gcnt[r_gi[GW-1:0]] <= w_gcnt_gi + CW'(1);
            end
        end
    end

    // Working registers of the current request.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mode  <= i_mode;
            r_count <= i_count;
            r_block <= i_block_number;
            r_rel   <= i_block_number - BLOCK_W'(r_fdb);
            r_left  <= i_count;
        end
        if (i_cmd.load_in || i_cmd.sum_clear || i_cmd.gi_clr) begin
            r_gi <= '0;
        end else if (i_cmd.sum_step || i_cmd.gi_inc || i_cmd.best_step || i_cmd.div_step) begin
            r_gi <= r_gi + GIW'(1);
        end
        if (i_cmd.sum_clear) begin
            r_sum <= '0;
        end else if (i_cmd.sum_step) begin
            r_sum <= w_sum_n;
        end
        if (i_cmd.div_step) begin
            r_rel <= r_rel - BLOCK_W'(GROUP_BLOCKS);
        end
        if (i_cmd.best_step && (r_gi == '0 || w_gcnt_gi > r_bestv)) begin
            r_best  <= r_gi[GW-1:0];
            r_bestv <= w_gcnt_gi;
        end
        if (i_cmd.set_fit) begin
            r_tgt  <= r_gi[GW-1:0];
            r_take <= r_count;
            r_word <= '0;
        end else if (i_cmd.set_best) begin
            r_tgt  <= r_best;
            r_take <= (32'(r_bestv) < 32'(r_left)) ? COUNT_W'(r_bestv) : r_left;
            r_word <= '0;
        end else if (i_cmd.word_inc) begin
            r_word <= r_word + WW'(1);
        end
        if (i_cmd.claim) begin
            r_take <= r_take - COUNT_W'(1);
            r_left <= r_left - COUNT_W'(1);
        end
        if (i_cmd.rd) begin
            r_rd_valid <= r_wvalid[w_addr];
        end
        if (i_cmd.ld_word) begin
            r_wreg <= r_rd_valid ? w_rdata : '0;
        end else if (i_cmd.claim) begin
            r_wreg <= w_claimed;
        end
    end

    // Result register: loads on emit, empties when the receiver takes it.
    assign w_out_free  = !r_o_valid || !i_stall;
    assign w_emit_bn   = r_mode ? r_block
                       : ((i_cmd.emit_st == ST_OK) ? w_claim_bn[BLOCK_W-1:0] : '0);
    assign w_emit_last = r_mode || (i_cmd.emit_st != ST_OK) || (r_left == COUNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_bn   <= w_emit_bn;
            r_o_st   <= i_cmd.emit_st;
            r_o_last <= w_emit_last;
        end
    end

    assign o_valid            = r_o_valid;
    assign o_block_number_res = r_o_bn;
    assign o_status           = r_o_st;
    assign o_last             = r_o_last;

    // Status toward the controller.
    always_comb begin
        o_stat            = '0;
        o_stat.cfg_wr     = i_cfg_we;
        o_stat.cfg_giu_wr = i_cfg_we && (i_cfg_index == CFG_GROUPS_IN_USE);
        o_stat.out_free   = w_out_free;
        o_stat.is_free    = r_mode;
        o_stat.bad_count  = (r_count == '0) || (32'(r_count) > MAX_REQUEST);
        o_stat.nospace    = 32'(r_count) > 32'(r_total);
        o_stat.free_bad   = (r_block == '0) || (r_block < BLOCK_W'(r_fdb));
        o_stat.sum_last   = (r_gi == r_giu - GIW'(1));
        o_stat.rel_lt     = 32'(r_rel) < GROUP_BLOCKS;
        o_stat.gi_ge_giu  = (r_gi >= r_giu);
        o_stat.gi_last    = (r_gi == r_giu - GIW'(1));
        o_stat.fit        = 32'(w_gcnt_gi) >= 32'(r_count);
        o_stat.bit_set    = r_wreg[r_rel[BW-1:0]];
        o_stat.has_free   = (w_freeb != '0);
        o_stat.left_one   = (r_left == COUNT_W'(1));
        o_stat.take_one   = (r_take == COUNT_W'(1));
    end

endmodule

// File: design/grouped_bitmap_block_allocator_core.sv
// Grouped bitmap block allocator, top level.
// Joins the controller (gbba_ctrl) and the datapath (gbba_dp). Depends on gbba_pkg.
//
// Usage: a request (mode, count, block_number) is taken when i_valid is high
// and o_stall is low. An allocate request yields one result per block, in
// order, with o_last on the final one; errors and frees yield one result.
// Results sit in an output register and are taken when o_valid is high and
// i_stall is low; while the receiver stalls, the sequencer holds and waits.
// One request is worked at a time. A free checks the request, steps through
// the groups below the freed block's group, reads the bitmap word and checks
// its bit. An allocate checks the request, scans the groups for one that fits
// (when none does, a best-group scan for the spacious group, repeated for each
// group drained), reads bitmap words from the single-port bitmap RAM in turn,
// moving on when a word is full, and claims its blocks. A groups_in_use write
// starts a pass over the groups in use that re-sums the total free count; no
// request is taken then.
// Reset marks every block free, sets 8 groups (at most NUM_GROUPS) and first
// data block 1; the bitmap needs no clearing pass, as each word has a valid bit.
`timescale 1ns / 1ps

module grouped_bitmap_block_allocator_core #(
    parameter int NUM_GROUPS   = gbba_pkg::NUM_GROUPS_DEF,
    parameter int GROUP_BLOCKS = gbba_pkg::GROUP_BLOCKS_DEF,
    parameter int MAX_REQUEST  = gbba_pkg::MAX_REQUEST_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_mode,
    input  logic [gbba_pkg::COUNT_W-1:0]    i_count,
    input  logic [gbba_pkg::BLOCK_W-1:0]    i_block_number,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [gbba_pkg::BLOCK_W-1:0]    o_block_number_res,
    output gbba_pkg::t_status               o_status,
    output logic                            o_last,
    input  logic                            i_cfg_we,
    input  logic [gbba_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gbba_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import gbba_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // Sequencer.
    gbba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // Storage, counters and result register.
    gbba_dp #(
        .NUM_GROUPS   (NUM_GROUPS),
        .GROUP_BLOCKS (GROUP_BLOCKS),
        .MAX_REQUEST  (MAX_REQUEST)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_mode             (i_mode),
        .i_count            (i_count),
        .i_block_number     (i_block_number),
        .i_stall            (i_stall),
        .i_cmd              (w_cmd),
        .o_stat             (w_stat),
        .o_valid            (o_valid),
        .o_block_number_res (o_block_number_res),
        .o_status           (o_status),
        .o_last             (o_last)
    );

    // A taken request keeps the input side closed on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input accepted while a request was still in work");

    // Error and no-space results always close their request.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> o_last)
        else $error("error result without last");

    // A no-space answer carries block number zero.
    a_nospace_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_NOSPACE) |-> (o_block_number_res == '0))
        else $error("no-space result with nonzero block number");

endmodule
